// ===== rtl/msq_pkg.sv =====
// ============================================================================
// msq_pkg - shared types and constants for the min squares decomposition
// Result layout, square-root unit status and fixed field widths.
// ============================================================================
package msq_pkg;

    localparam int COUNT_W      = 3;
    localparam int ROOT_OUT_W   = 12;
    localparam int MULTI_W      = 3;
    localparam int MAX_SQUARES  = 4;
    localparam int MAX_RESULTS  = 64;
    localparam int CNT_W        = $clog2(MAX_RESULTS + 1);
    localparam int OUT_TDATA_W  = 56;

    localparam logic [MULTI_W-1:0] MULTI_RESET = 3'd2;

    // Packed so that count lands in the lowest bits, then root_a .. root_d.
    typedef struct packed {
        logic [ROOT_OUT_W-1:0] root_d;
        logic [ROOT_OUT_W-1:0] root_c;
        logic [ROOT_OUT_W-1:0] root_b;
        logic [ROOT_OUT_W-1:0] root_a;
        logic [COUNT_W-1:0]    count;
    } t_result;

    localparam int OUT_PAD_W = OUT_TDATA_W - $bits(t_result);

    typedef struct packed {
        logic busy;
        logic done;
    } t_sqrt_stat;

endpackage

// ===== rtl/msq_sqrt.sv =====
// ============================================================================
// msq_sqrt - iterative floor square root
// Digit-by-digit method, one result bit per cycle, done pulses for one cycle.
// ============================================================================
module msq_sqrt
    import msq_pkg::*;
#(
    parameter int VALUE_BITS = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [VALUE_BITS-1:0]             i_operand,
    output logic [(VALUE_BITS+1)/2-1:0]       o_root,
    output t_sqrt_stat                        o_stat
);

    localparam int RW = (VALUE_BITS + 1) / 2;
    localparam int W  = 2 * RW;

    logic [W-1:0] r_v;
    logic [W-1:0] r_res;
    logic [W-1:0] r_bit;
    logic         r_busy;
    logic         r_done;

    logic [W:0]   trial;
    logic         take;

    assign trial = {1'b0, r_res} + {1'b0, r_bit};
    assign take  = ({1'b0, r_v} >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_v    <= W'(i_operand);
                r_res  <= '0;
                r_bit  <= W'(1) << (W - 2);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (take) begin
                    r_v   <= r_v - trial[W-1:0];
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                if (r_bit[0]) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_root      = r_res[RW-1:0];
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

// ===== rtl/min_squares_decomposition.sv =====
// ============================================================================
// min_squares_decomposition - fewest squares that sum to an integer
// Greedy floor-square-root search with descending backtrack, k = 1 .. 4.
// ============================================================================
//
// Channel   Dir  Handshake                 Payload
// --------  ---  ------------------------  ---------------------------------
// s_axis    in   s_axis_tvalid/tready      tdata: value
// m_axis    out  m_axis_tvalid/tready      tdata: count, root_a..root_d
//                                          tlast: last
// cfg       in   i_cfg_we (no wait)        i_cfg_wdata: multi
//
// Timing: one request is held for a data-dependent run. Each greedy root runs
// the bit-serial square-root unit and then the shared squaring multiplier; a
// backtrack step reloads the multiplier, twice when the second root is
// lowered, and a finished candidate is checked and emitted while the output
// is free. A full sweep over a 24-bit value runs far longer than a small one.
// Reset: synchronous, active low; multi returns to 2, no result pending.
// Stalls: s_axis_tready is high only while the sequencer is idle. One result
// is held back in a pending register so that tlast is known when it leaves;
// a stalled output register halts the sequencer at the next emit.
// ============================================================================
module min_squares_decomposition
    import msq_pkg::*;
#(
    parameter int VALUE_BITS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration: multi
    input  logic                                i_cfg_we,
    input  logic [MULTI_W-1:0]                  i_cfg_wdata,
    // tdata: [VALUE_BITS-1:0] value, upper bits zero
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [((VALUE_BITS+7)/8)*8-1:0]     s_axis_tdata,
    // tdata: [2:0] count, [14:3] root_a, [26:15] root_b, [38:27] root_c,
    //        [50:39] root_d, upper bits zero
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [OUT_TDATA_W-1:0]              m_axis_tdata,
    output logic                                m_axis_tlast
);

    localparam int RW = (VALUE_BITS + 1) / 2;
    localparam int W  = 2 * RW;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_DESCEND,
        S_SQRT,
        S_MUL,
        S_SUB,
        S_CHECK,
        S_EMIT,
        S_AFTER_HIT,
        S_BACK,
        S_BT_R1,
        S_KEND,
        S_FINISH
    } t_state;

    t_state                r_state;
    t_state                r_sub_next;
    logic [VALUE_BITS-1:0] r_v;
    logic [VALUE_BITS-1:0] r_rem;
    logic [VALUE_BITS-1:0] r_saved;
    logic [RW-1:0]         r_roots [MAX_SQUARES];
    logic [2:0]            r_k;
    logic [2:0]            r_i;
    logic                  r_found;
    logic [MULTI_W-1:0]    r_multi;
    logic [RW-1:0]         r_mul_op;
    logic [W-1:0]          r_prod;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_pend_v;
    t_result               r_pend;
    logic                  r_out_v;
    t_result               r_out;
    logic                  r_out_last;

    logic [RW-1:0]         sq_root;
    t_sqrt_stat            sq_stat;
    logic                  sq_start;
    logic [W-1:0]          diff;
    logic [1:0]            last_idx;
    logic [RW-1:0]         root_last;
    logic                  sorted;
    logic                  out_free;
    logic                  out_push;
    t_result               hit;

    msq_sqrt #(
        .VALUE_BITS (VALUE_BITS)
    ) u_sqrt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (sq_start),
        .i_operand (r_rem),
        .o_root    (sq_root),
        .o_stat    (sq_stat)
    );

    function automatic logic [ROOT_OUT_W-1:0] trim_root(input logic [RW-1:0] root);
        logic [RW+ROOT_OUT_W-1:0] ext;
        ext = {{ROOT_OUT_W{1'b0}}, root};
        return ext[ROOT_OUT_W-1:0];
    endfunction

    // Launch a root whenever the greedy descent still has positions to fill.
    assign sq_start  = (r_state == S_DESCEND) && (r_i < r_k);
    assign diff      = W'(r_rem) - r_prod;
    assign last_idx  = r_k[1:0] - 2'd1;
    assign root_last = r_roots[last_idx];
    assign out_free  = !r_out_v || m_axis_tready;
    // move the pending result into the output register
    assign out_push  = r_pend_v && out_free &&
                       ((r_state == S_EMIT) || (r_state == S_FINISH));

    // A hit only counts when the roots come out non-increasing.
    assign sorted = ((r_k < 3'd2) || (r_roots[0] >= r_roots[1])) &&
                    ((r_k < 3'd3) || (r_roots[1] >= r_roots[2])) &&
                    ((r_k < 3'd4) || (r_roots[2] >= r_roots[3]));

    always_comb begin
        hit.count  = r_k;
        hit.root_a = trim_root(r_roots[0]);
        hit.root_b = (r_k >= 3'd2) ? trim_root(r_roots[1]) : '0;
        hit.root_c = (r_k >= 3'd3) ? trim_root(r_roots[2]) : '0;
        hit.root_d = (r_k >= 3'd4) ? trim_root(r_roots[3]) : '0;
    end

    // Shared squaring unit: operand loaded one cycle, product registered next.
    always_ff @(posedge i_clk) begin
        r_prod <= W'(r_mul_op) * W'(r_mul_op);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_sub_next <= S_DESCEND;
            r_multi    <= MULTI_RESET;
            r_k        <= '0;
            r_i        <= '0;
            r_found    <= 1'b0;
            r_cnt      <= '0;
            r_pend_v   <= 1'b0;
            r_out_v    <= 1'b0;
            r_rem      <= '0;
            r_saved    <= '0;
            for (int j = 0; j < MAX_SQUARES; j++) begin
                r_roots[j] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_multi <= i_cfg_wdata;
            end
            // load the output from the pending slot, else drop it once taken
            if (out_push) begin
                r_out_v <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_v <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_v     <= s_axis_tdata[VALUE_BITS-1:0];
                        r_k     <= 3'd1;
                        r_cnt   <= '0;
                        r_state <= S_INIT;
                    end
                end
                S_INIT: begin
                    r_i     <= '0;
                    r_rem   <= r_v;
                    r_saved <= '0;
                    r_found <= 1'b0;
                    r_state <= S_DESCEND;
                end
                S_DESCEND: begin
                    if (r_i < r_k) begin
                        // hold the remainder ahead of the third root for backtrack
                        if (r_i == 3'd2) begin
                            r_saved <= r_rem;
                        end
                        r_state <= S_SQRT;
                    end else begin
                        r_state <= S_CHECK;
                    end
                end
                S_SQRT: begin
                    if (sq_stat.done) begin
                        r_roots[r_i[1:0]] <= sq_root;
                        r_mul_op          <= sq_root;
                        r_i               <= r_i + 3'd1;
                        r_sub_next        <= S_DESCEND;
                        r_state           <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_SUB;
                end
                S_SUB: begin
                    r_rem   <= diff[VALUE_BITS-1:0];
                    r_state <= r_sub_next;
                end
                S_CHECK: begin
                    if (r_rem != '0) begin
                        r_state <= S_BACK;
                    end else if (sorted) begin
                        r_found <= 1'b1;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_AFTER_HIT;
                    end
                end
                S_EMIT: begin
                    // flush the older pending result first; it is not the last
                    if (!r_pend_v || out_free) begin
                        if (r_pend_v) begin
                            r_out      <= r_pend;
                            r_out_last <= 1'b0;
                        end
                        r_pend   <= hit;
                        r_pend_v <= 1'b1;
                        r_cnt    <= r_cnt + CNT_W'(1);
                        if (r_cnt == CNT_W'(MAX_RESULTS - 1)) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_state <= S_AFTER_HIT;
                        end
                    end
                end
                S_AFTER_HIT: begin
                    if ((r_k < 3'd2) || (r_k > r_multi)) begin
                        r_state <= S_KEND;
                    end else begin
                        r_state <= S_BACK;
                    end
                end
                S_BACK: begin
                    if ((r_k == 3'd4) && (r_roots[2] > r_roots[3])) begin
                        r_roots[2] <= r_roots[2] - RW'(1);
                        r_mul_op   <= r_roots[2] - RW'(1);
                        r_rem      <= r_saved;
                        r_i        <= 3'd3;
                        r_sub_next <= S_DESCEND;
                        r_state    <= S_MUL;
                    end else if ((r_k >= 3'd3) && (r_roots[1] > root_last)) begin
                        r_roots[1] <= r_roots[1] - RW'(1);
                        r_mul_op   <= r_roots[0];
                        r_rem      <= r_v;
                        r_i        <= 3'd2;
                        r_sub_next <= S_BT_R1;
                        r_state    <= S_MUL;
                    end else if ((r_k >= 3'd2) && (r_roots[0] > root_last)) begin
                        r_roots[0] <= r_roots[0] - RW'(1);
                        r_mul_op   <= r_roots[0] - RW'(1);
                        r_rem      <= r_v;
                        r_i        <= 3'd1;
                        r_sub_next <= S_DESCEND;
                        r_state    <= S_MUL;
                    end else begin
                        r_state <= S_KEND;
                    end
                end
                S_BT_R1: begin
                    // second square of the rebuilt remainder
                    r_mul_op   <= r_roots[1];
                    r_sub_next <= S_DESCEND;
                    r_state    <= S_MUL;
                end
                S_KEND: begin
                    if (r_found || (r_k == 3'(MAX_SQUARES))) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_k     <= r_k + 3'd1;
                        r_state <= S_INIT;
                    end
                end
                S_FINISH: begin
                    if (!r_pend_v) begin
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_out      <= r_pend;
                        r_out_last <= 1'b1;
                        r_pend_v   <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out};
    assign m_axis_tlast  = r_out_last;

endmodule

// ===== rtl/msq_checker.sv =====
// ============================================================================
// msq_checker - port-level checks for the min squares decomposition
// Watches request acceptance and result formatting on the top-level ports.
// ============================================================================
module msq_checker
    import msq_pkg::*;
(
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [OUT_TDATA_W-1:0]              m_axis_tdata,
    input  logic                                m_axis_tlast
);

    t_result res;
    assign res = m_axis_tdata[$bits(t_result)-1:0];

    // a request occupies the sequencer for at least the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after an accepted request");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (res.count != 3'd0) && (res.count <= 3'(MAX_SQUARES)))
        else $error("result square count out of range");

    a_unused_roots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((res.count >= 3'd2) || (res.root_b == '0)) &&
                          ((res.count >= 3'd3) || (res.root_c == '0)) &&
                          ((res.count >= 3'd4) || (res.root_d == '0)))
        else $error("unused root field not zero");

endmodule

bind min_squares_decomposition msq_checker u_msq_checker (.*);
